// ===== rtl/rcdf_pkg.sv =====
// Package for the record change delta filter: types, table geometry and codes.
`timescale 1ns / 1ps

package rcdf_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int THR_W = 31;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [THR_W-1:0] MOTION_THR_RST = THR_W'(655);
	localparam logic [THR_W-1:0] RISK_THR_RST = THR_W'(66);

	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RISK_THR = CFG_IDX_W'(1);

	typedef struct packed {
		logic [9:0]         object_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] risk_level;
		logic [15:0]        obj_size;
	} rec_t;

	typedef struct packed {
		logic [9:0]         out_id;
		logic               is_new;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
		logic signed [31:0] out_risk;
		logic [15:0]        out_size;
	} upd_t;

	// stored part of a record
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] risk;
		logic [15:0]        size;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clear_en;
		logic load_in;
		logic rd_en;
		logic cmp_en;
		logic wr_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic emit;
		logic out_busy;
	} sts_t;

	// |a - b| > limit, difference formed exactly in 33 bits
	function automatic logic exceeds(logic [31:0] a, logic [31:0] b, logic [THR_W-1:0] limit);
		logic signed [32:0] d;
		logic [32:0]        mag;
		begin
			d = $signed({a[31], a}) - $signed({b[31], b});
			mag = d[32] ? 33'(-d) : 33'(d);
			return mag > {2'b00, limit};
		end
	endfunction

endpackage

// ===== rtl/record_change_delta_filter.sv =====
// Top level of the record change delta filter.
//
//  channel  dir  handshake              payload
//  rec      in   rec_valid / rec_stall  rec_data  (rcdf_pkg::rec_t)
//  upd      out  upd_valid / upd_stall  upd_data  (rcdf_pkg::upd_t)
//  cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Each transaction runs through accept, table read, compare, table write and
//  result load; the single-port record table sets this sequence.
//  After reset all TABLE_DEPTH (1024) valid-table entries are cleared, with rec_stall high.
//  The result register frees the input side; a second result waits in the write
//  step while the first is stalled. cfg_ready is always high.
`timescale 1ns / 1ps

module record_change_delta_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rec_valid,
	output logic                            rec_stall,
	input  rcdf_pkg::rec_t                  rec_data,
	output logic                            upd_valid,
	input  logic                            upd_stall,
	output rcdf_pkg::upd_t                  upd_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rcdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcdf_pkg::CFG_DATA_W-1:0] cfg_data
);

	rcdf_pkg::cmd_t cmd;
	rcdf_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rcdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcdf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.rec_data  (rec_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.upd_valid (upd_valid),
		.upd_stall (upd_stall),
		.upd_data  (upd_data)
	);

endmodule

// ===== rtl/rcdf_ctrl.sv =====
// Controller state machine: table clear sweep and per-transaction sequencing.
`timescale 1ns / 1ps

module rcdf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	output logic           rec_stall,
	input  rcdf_pkg::sts_t sts,
	output rcdf_pkg::cmd_t cmd
);

	rcdf_pkg::state_t state_q;
	rcdf_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcdf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rcdf_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_nx = rcdf_pkg::ST_IDLE;
			end
			rcdf_pkg::ST_IDLE: begin
				if (rec_valid) state_nx = rcdf_pkg::ST_READ;
			end
			rcdf_pkg::ST_READ:  state_nx = rcdf_pkg::ST_CMP;
			rcdf_pkg::ST_CMP:   state_nx = rcdf_pkg::ST_WRITE;
			rcdf_pkg::ST_WRITE: begin
				if (!(sts.emit && sts.out_busy)) state_nx = rcdf_pkg::ST_IDLE;
			end
			default: state_nx = rcdf_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		rec_stall = 1'b1;
		unique case (state_q)
			rcdf_pkg::ST_CLEAR: cmd.clear_en = 1'b1;
			rcdf_pkg::ST_IDLE: begin
				rec_stall = 1'b0;
				cmd.load_in = rec_valid;
			end
			rcdf_pkg::ST_READ: cmd.rd_en = 1'b1;
			rcdf_pkg::ST_CMP:  cmd.cmp_en = 1'b1;
			rcdf_pkg::ST_WRITE: begin
				cmd.wr_en = 1'b1;
				cmd.out_load = sts.emit && !sts.out_busy;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/rcdf_dp.sv =====
// Datapath: thresholds, record table, valid table, change compare and output register.
`timescale 1ns / 1ps

module rcdf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcdf_pkg::cmd_t                      cmd,
	output rcdf_pkg::sts_t                      sts,
	input  rcdf_pkg::rec_t                      rec_data,
	input  logic                                cfg_valid,
	input  logic [rcdf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcdf_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                upd_valid,
	input  logic                                upd_stall,
	output rcdf_pkg::upd_t                      upd_data
);

	logic [rcdf_pkg::THR_W-1:0] motion_thr_q;
	logic [rcdf_pkg::THR_W-1:0] risk_thr_q;

	rcdf_pkg::entry_t           tbl_mem [rcdf_pkg::TABLE_DEPTH];
	logic                       vld_mem [rcdf_pkg::TABLE_DEPTH];

	logic [rcdf_pkg::IDX_W-1:0] clr_cnt_q;
	rcdf_pkg::rec_t             item_q;
	logic [rcdf_pkg::IDX_W-1:0] slot;
	rcdf_pkg::entry_t           rd_q;
	rcdf_pkg::entry_t           wr_entry;
	logic                       vld_rd_q;
	logic                       emit_q;
	logic                       is_new_q;
	logic                       changed;
	logic                       out_valid_q;
	rcdf_pkg::upd_t             out_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_thr_q <= rcdf_pkg::MOTION_THR_RST;
			risk_thr_q <= rcdf_pkg::RISK_THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rcdf_pkg::REG_MOTION_THR: motion_thr_q <= cfg_data[rcdf_pkg::THR_W-1:0];
				rcdf_pkg::REG_RISK_THR:   risk_thr_q <= cfg_data[rcdf_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) item_q <= rec_data;
	end

	assign slot = rcdf_pkg::IDX_W'(item_q.object_id);

	assign wr_entry = '{
		pos_x: item_q.pos_x,
		pos_y: item_q.pos_y,
		vel_x: item_q.vel_x,
		vel_y: item_q.vel_y,
		risk:  item_q.risk_level,
		size:  item_q.obj_size
	};

	always_ff @(posedge clk) begin
		if (cmd.wr_en) tbl_mem[slot] <= wr_entry;
		if (cmd.rd_en) rd_q <= tbl_mem[slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			vld_mem[clr_cnt_q] <= 1'b0;
		end else if (cmd.wr_en) begin
			vld_mem[slot] <= 1'b1;
		end
		if (cmd.rd_en) vld_rd_q <= vld_mem[slot];
	end

	assign changed = rcdf_pkg::exceeds(rd_q.pos_x, item_q.pos_x, motion_thr_q)
		|| rcdf_pkg::exceeds(rd_q.pos_y, item_q.pos_y, motion_thr_q)
		|| rcdf_pkg::exceeds(rd_q.vel_x, item_q.vel_x, motion_thr_q)
		|| rcdf_pkg::exceeds(rd_q.vel_y, item_q.vel_y, motion_thr_q)
		|| rcdf_pkg::exceeds(rd_q.risk, item_q.risk_level, risk_thr_q)
		|| (rd_q.size != item_q.obj_size);

	always_ff @(posedge clk) begin
		if (cmd.cmp_en) begin
			is_new_q <= !vld_rd_q;
			emit_q <= !vld_rd_q || changed;
		end
	end

	assign sts = '{
		clear_last: (clr_cnt_q == rcdf_pkg::IDX_W'(rcdf_pkg::TABLE_DEPTH - 1)),
		emit:       emit_q,
		out_busy:   out_valid_q && upd_stall
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!upd_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= '{
				out_id:    item_q.object_id,
				is_new:    is_new_q,
				out_pos_x: item_q.pos_x,
				out_pos_y: item_q.pos_y,
				out_vel_x: item_q.vel_x,
				out_vel_y: item_q.vel_y,
				out_risk:  item_q.risk_level,
				out_size:  item_q.obj_size
			};
		end
	end

	assign upd_valid = out_valid_q;
	assign upd_data = out_q;

endmodule

// ===== tb/tb.sv =====
// Testbench for record_change_delta_filter: directed and random records vs. a predictor.
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 40;
	localparam int POOL_SIZE = 12;

	// indexes with no register behind them
	localparam logic [rcdf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = rcdf_pkg::CFG_IDX_W'(2);
	localparam logic [rcdf_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rec_valid = 1'b0;
	logic rec_stall;
	rcdf_pkg::rec_t rec_data = '0;
	logic upd_valid;
	logic upd_stall = 1'b0;
	rcdf_pkg::upd_t upd_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rcdf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rcdf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [rcdf_pkg::THR_W-1:0] motion_lim = rcdf_pkg::MOTION_THR_RST;
	logic [rcdf_pkg::THR_W-1:0] risk_lim = rcdf_pkg::RISK_THR_RST;
	bit seen_tbl [rcdf_pkg::TABLE_DEPTH];
	rcdf_pkg::rec_t stored_tbl [rcdf_pkg::TABLE_DEPTH];

	// generator state
	logic [rcdf_pkg::THR_W-1:0] gen_motion = rcdf_pkg::MOTION_THR_RST;
	logic [rcdf_pkg::THR_W-1:0] gen_risk = rcdf_pkg::RISK_THR_RST;
	bit gen_seen [rcdf_pkg::TABLE_DEPTH];
	rcdf_pkg::rec_t gen_last [rcdf_pkg::TABLE_DEPTH];
	int id_pool [POOL_SIZE];
	logic [9:0] last_id = '0;

	rcdf_pkg::rec_t record_q [$];
	rcdf_pkg::upd_t update_q [$];

	int err_count = 0;
	int items_in = 0;
	int updates_out = 0;
	int new_out = 0;
	int quiet_items = 0;
	int cycles = 0;
	int hold_phase = 0;

	record_change_delta_filter uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timed out after %0d cycles, %0d updates still due", cycles, update_q.size());
			$display("record_change_delta_filter: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (err_count < MAX_REPORTS)
			$display("%0t %s: got %h, expected %h", $time, what, got, want);
		err_count++;
	endtask

	function automatic bit changed_beyond(logic signed [31:0] was, logic signed [31:0] now,
			logic [rcdf_pkg::THR_W-1:0] lim);
		longint gap;
		gap = longint'(was) - longint'(now);
		if (gap < 0)
			gap = -gap;
		return gap > longint'(lim);
	endfunction

	task automatic predict_update(rcdf_pkg::rec_t r);
		int slot;
		bit fresh;
		bit moved;
		rcdf_pkg::rec_t prev;
		rcdf_pkg::upd_t u;
		slot = r.object_id % rcdf_pkg::TABLE_DEPTH;
		fresh = !seen_tbl[slot];
		prev = stored_tbl[slot];
		moved = !fresh && (changed_beyond(prev.pos_x, r.pos_x, motion_lim) ||
			changed_beyond(prev.pos_y, r.pos_y, motion_lim) ||
			changed_beyond(prev.vel_x, r.vel_x, motion_lim) ||
			changed_beyond(prev.vel_y, r.vel_y, motion_lim) ||
			changed_beyond(prev.risk_level, r.risk_level, risk_lim) ||
			prev.obj_size != r.obj_size);
		seen_tbl[slot] = 1'b1;
		stored_tbl[slot] = r;
		items_in++;
		if (fresh || moved) begin
			u.out_id = r.object_id;
			u.is_new = fresh;
			u.out_pos_x = r.pos_x;
			u.out_pos_y = r.pos_y;
			u.out_vel_x = r.vel_x;
			u.out_vel_y = r.vel_y;
			u.out_risk = r.risk_level;
			u.out_size = r.obj_size;
			update_q.insert(update_q.size(), u);
		end else begin
			quiet_items++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcdf_pkg::REG_MOTION_THR: motion_lim = cfg_data[rcdf_pkg::THR_W-1:0];
				rcdf_pkg::REG_RISK_THR: risk_lim = cfg_data[rcdf_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// sender: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (!rec_valid || !rec_stall) begin
			if (rec_valid)
				predict_update(rec_data);
			if (gap_left > 0) begin
				rec_valid <= 1'b0;
				gap_left--;
			end else if (record_q.size() > 0) begin
				rec_valid <= 1'b1;
				rec_data <= record_q.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				rec_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern, plus a long hold-off on request
	int held_phase = 0;
	int hold_left = 0;
	int mode = 0;
	int mode_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			upd_stall <= 1'b0;
		end else if (hold_phase != held_phase) begin
			held_phase = hold_phase;
			hold_left = HOLD_CYCLES;
			upd_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			upd_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: upd_stall <= 1'b0;
				1: upd_stall <= ($urandom_range(0, 3) == 0);
				2: upd_stall <= ($urandom_range(0, 3) != 0);
				default: upd_stall <= mode_left[3];
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		rcdf_pkg::upd_t want;
		if (arst_n && upd_valid && !upd_stall) begin
			if (update_q.size() == 0) begin
				report_mismatch("unexpected update, out_id", 32'(upd_data.out_id), '0);
			end else begin
				want = update_q.pop_front();
				updates_out++;
				if (want.is_new)
					new_out++;
				if (upd_data.out_id !== want.out_id)
					report_mismatch("out_id", 32'(upd_data.out_id), 32'(want.out_id));
				if (upd_data.is_new !== want.is_new)
					report_mismatch("is_new", 32'(upd_data.is_new), 32'(want.is_new));
				if (upd_data.out_pos_x !== want.out_pos_x)
					report_mismatch("out_pos_x", upd_data.out_pos_x, want.out_pos_x);
				if (upd_data.out_pos_y !== want.out_pos_y)
					report_mismatch("out_pos_y", upd_data.out_pos_y, want.out_pos_y);
				if (upd_data.out_vel_x !== want.out_vel_x)
					report_mismatch("out_vel_x", upd_data.out_vel_x, want.out_vel_x);
				if (upd_data.out_vel_y !== want.out_vel_y)
					report_mismatch("out_vel_y", upd_data.out_vel_y, want.out_vel_y);
				if (upd_data.out_risk !== want.out_risk)
					report_mismatch("out_risk", upd_data.out_risk, want.out_risk);
				if (upd_data.out_size !== want.out_size)
					report_mismatch("out_size", 32'(upd_data.out_size), 32'(want.out_size));
			end
		end
	end

	function automatic rcdf_pkg::rec_t mk(logic [9:0] id, logic [31:0] px, logic [31:0] py,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] rk, logic [15:0] sz);
		rcdf_pkg::rec_t r;
		r.object_id = id;
		r.pos_x = px;
		r.pos_y = py;
		r.vel_x = vx;
		r.vel_y = vy;
		r.risk_level = rk;
		r.obj_size = sz;
		return r;
	endfunction

	task automatic queue_record(rcdf_pkg::rec_t r);
		record_q.insert(record_q.size(), r);
		gen_seen[r.object_id] = 1'b1;
		gen_last[r.object_id] = r;
	endtask

	task automatic new_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = $urandom_range(0, rcdf_pkg::TABLE_DEPTH - 1);
		id_pool[0] = 0;
		id_pool[1] = rcdf_pkg::TABLE_DEPTH - 1;
	endtask

	// mostly zero; otherwise a step around the limit or a wild jump
	function automatic logic [31:0] nudge(logic [rcdf_pkg::THR_W-1:0] lim);
		logic [31:0] step;
		if ($urandom_range(0, 3) != 0)
			return '0;
		case ($urandom_range(0, 6))
			0: step = lim;
			1: step = lim + 1;
			2: step = (lim == 0) ? '0 : lim - 1;
			3: step = lim / 2;
			4: step = $urandom_range(1, 3);
			5: step = lim + $urandom_range(2, 500);
			default: step = $urandom;
		endcase
		return $urandom_range(0, 1) ? -step : step;
	endfunction

	task automatic queue_random(int count);
		rcdf_pkg::rec_t r;
		logic [9:0] id;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0: id = 10'($urandom_range(0, rcdf_pkg::TABLE_DEPTH - 1));
				1, 2: id = last_id;
				default: id = 10'(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
			endcase
			if (!gen_seen[id] || $urandom_range(0, 9) == 0) begin
				r.pos_x = $urandom;
				r.pos_y = $urandom;
				r.vel_x = $urandom;
				r.vel_y = $urandom;
				r.risk_level = $urandom;
				r.obj_size = 16'($urandom_range(0, 65535));
			end else begin
				r = gen_last[id];
				r.pos_x = r.pos_x + nudge(gen_motion);
				r.pos_y = r.pos_y + nudge(gen_motion);
				r.vel_x = r.vel_x + nudge(gen_motion);
				r.vel_y = r.vel_y + nudge(gen_motion);
				r.risk_level = r.risk_level + nudge(gen_risk);
				case ($urandom_range(0, 9))
					0: r.obj_size = r.obj_size + 16'd1;
					1: r.obj_size = 16'($urandom_range(0, 65535));
					default: ;
				endcase
			end
			r.object_id = id;
			queue_record(r);
			last_id = id;
		end
	endtask

	task automatic cfg_write(logic [rcdf_pkg::CFG_IDX_W-1:0] idx,
			logic [rcdf_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(logic [31:0] m, logic [31:0] r);
		cfg_write(rcdf_pkg::REG_MOTION_THR, m);
		cfg_write(rcdf_pkg::REG_RISK_THR, r);
		gen_motion = m[rcdf_pkg::THR_W-1:0];
		gen_risk = r[rcdf_pkg::THR_W-1:0];
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (record_q.size() != 0 || rec_valid || update_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		new_pool();

		// reset limits: equal-to-limit changes stay quiet
		queue_record(mk(10'd0, 0, 0, 0, 0, 0, 16'h0000));
		queue_record(mk(10'h3FF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
		queue_record(mk(10'd0, 0, 0, 0, 0, 0, 16'h0000));
		queue_record(mk(10'd0, 655, 0, 0, 0, 0, 16'h0000));
		queue_record(mk(10'd0, 1311, 0, 0, 0, 0, 16'h0000));
		queue_record(mk(10'd0, 1311, -656, 0, 0, 0, 16'h0000));
		queue_record(mk(10'd0, 1311, -656, 656, 0, 0, 16'h0000));
		queue_record(mk(10'd0, 1311, -656, 656, -656, 0, 16'h0000));
		queue_record(mk(10'd0, 1311, -656, 656, -656, 66, 16'h0000));
		queue_record(mk(10'd0, 1311, -656, 656, -656, 133, 16'h0000));
		queue_record(mk(10'd0, 1311, -656, 656, -656, 133, 16'h0001));
		queue_record(mk(10'd0, 1311, -656, 656, -656, 133, 16'h0000));
		queue_record(mk(10'h3FF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
		queue_record(mk(10'h3FF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFD70, 32'h7FFFFFBD, 16'hFFFF));
		queue_record(mk(10'd512, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 16'h8000));
		queue_record(mk(10'd511, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
			32'hAAAAAAAA, 32'h55555555, 16'h5555));
		queue_record(mk(10'd511, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
			32'h55555555, 32'hAAAAAAAA, 16'hAAAA));
		wait_idle();

		// full-scale limits, bit 31 of the data dropped
		set_limits(32'hFFFFFFFF, 32'hFFFFFFFF);
		cfg_write(CFG_IDX_SPARE, 32'h0000_0000);
		queue_record(mk(10'd5, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 16'h0000));
		queue_record(mk(10'd5, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 16'h0000));
		queue_record(mk(10'd5, 32'hFFFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 16'h0000));
		queue_record(mk(10'd5, 32'h7FFFFFFE, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 16'h0000));
		queue_record(mk(10'd5, 32'h7FFFFFFE, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 16'h0000));
		queue_random(150);
		wait_idle();

		set_limits(32'd0, 32'd0);
		new_pool();
		queue_random(200);
		wait_idle();

		set_limits(32'(rcdf_pkg::MOTION_THR_RST), 32'(rcdf_pkg::RISK_THR_RST));
		new_pool();
		queue_random(250);
		hold_phase = 1;
		wait_idle();

		set_limits($urandom_range(0, 2000), $urandom_range(0, 200));
		cfg_write(CFG_IDX_TOP, 32'hFFFFFFFF);
		queue_random(250);
		wait_idle();

		set_limits($urandom, $urandom_range(0, 100));
		queue_random(200);
		wait_idle();

		set_limits($urandom_range(0, 16), 32'h7FFFFFFF);
		new_pool();
		queue_random(200);
		hold_phase = 2;
		wait_idle();

		$display("%0d records in, %0d updates checked (%0d first sightings), %0d filtered out",
			items_in, updates_out, new_out, quiet_items);
		$display("thresholds swept from zero to full scale, two long output holds");
		if (err_count == 0)
			$display("record_change_delta_filter: match");
		else
			$display("record_change_delta_filter: mismatch");
		$finish;
	end

endmodule
